// File: sv/ring_queue_with_slot_status_macros.svh
// assertion macros for the ring queue checker
// depends on nothing; included by the checker file
`ifndef RING_QUEUE_WITH_SLOT_STATUS_MACROS_SVH
`define RING_QUEUE_WITH_SLOT_STATUS_MACROS_SVH

// same-cycle implication, held off during reset
`define RQSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RQSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rqss_pkg.sv
// shared types and constants for the ring queue with slot status
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rqss_pkg;

    localparam int SLOTS        = 16;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int CNT_W        = $clog2(SLOTS + 1);
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = 8;
    localparam int ACT_W        = 2;
    localparam int WANT_W       = 2;
    localparam int CODE_W       = 3;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_CREATED  = 2'd1,
        ST_PREPARED = 2'd2,
        ST_SENT     = 2'd3
    } t_status;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_FIND    = 2'd1,
        ACT_PREPARE = 2'd2,
        ACT_SEND    = 2'd3
    } t_action;

    typedef enum logic [CODE_W-1:0] {
        RC_OK           = 3'd0,
        RC_FULL         = 3'd1,
        RC_NOT_FOUND    = 3'd2,
        RC_BAD_INDEX    = 3'd3,
        RC_WRONG_STATUS = 3'd4
    } t_result;

endpackage

`default_nettype wire

// File: sv/rqss_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module rqss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/ring_queue_with_slot_status.sv
// top level of the ring queue with per-slot status
// depends on rqss_pkg and rqss_ram
`timescale 1ns / 1ps
`default_nettype none
//
// Usage:
//  - input channel i_valid / o_ready carries one request item: action, payload,
//    slot index and wanted status. output channel o_valid / i_ready carries one
//    result item per request: result code, slot, payload and the two counts.
//  - a request is taken in the idle state. status, pointers and counts are
//    updated at that edge; the payload ram is written (push) or read (find)
//    in the same cycle. the ram read data is registered at that edge, and the
//    result is loaded from it into the output register in the result state.
//  - a new request is not taken until the result of the last one has been
//    loaded into the output register. the next request may be taken while a
//    finished result still waits in the output register.
//  - if the receiver stalls, the next result waits inside the block and no
//    further request is taken until the output register frees up.
//  - synchronous active-low reset empties every slot, clears pointers and
//    counts and drops o_valid. the payload ram is not cleared; a find only
//    ever returns a slot that a push has written.
//
module ring_queue_with_slot_status (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [rqss_pkg::ACT_W-1:0]          i_action,
    input  wire logic [rqss_pkg::PAYLOAD_BITS-1:0]   i_payload_in,
    input  wire logic [rqss_pkg::IDX_W-1:0]          i_slot_index,
    input  wire logic [rqss_pkg::WANT_W-1:0]         i_wanted_status,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic      [rqss_pkg::CODE_W-1:0]         o_result_code,
    output logic      [rqss_pkg::SLOT_W-1:0]         o_slot_out,
    output logic      [rqss_pkg::PAYLOAD_BITS-1:0]   o_payload_out,
    output logic      [rqss_pkg::CNT_W-1:0]          o_created_count,
    output logic      [rqss_pkg::CNT_W-1:0]          o_prepared_count
);

    import rqss_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } t_state;

    t_state                  r_state, n_state;
    t_status                 r_status [SLOTS];
    t_status                 n_status [SLOTS];
    logic [SLOT_W-1:0]       r_head, n_head;
    logic                    r_head_valid, n_head_valid;
    logic [SLOT_W-1:0]       r_tail, n_tail;
    logic [CNT_W-1:0]        r_created, n_created;
    logic [CNT_W-1:0]        r_prepared, n_prepared;
    t_result                 r_pend_code, n_pend_code;
    logic [SLOT_W-1:0]       r_pend_slot, n_pend_slot;
    logic                    r_pend_found, n_pend_found;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out_code, n_out_code;
    logic [SLOT_W-1:0]       r_out_slot, n_out_slot;
    logic [PAYLOAD_BITS-1:0] r_out_payload, n_out_payload;
    logic [CNT_W-1:0]        r_out_created, n_out_created;
    logic [CNT_W-1:0]        r_out_prepared, n_out_prepared;

    logic                    accept;
    logic                    full;
    logic [SLOT_W-1:0]       occ;
    t_status                 target;
    logic [SLOTS-1:0]        match;
    logic [SLOTS-1:0]        match_rot;
    logic [SLOT_W-1:0]       pick_off;
    logic [SLOT_W-1:0]       pick_slot;
    logic                    found_any;
    logic [SLOT_W-1:0]       idx;
    logic                    bad_idx;
    t_status                 need;
    t_status                 head_st;
    logic                    ram_we;
    logic                    ram_re;
    logic [PAYLOAD_BITS-1:0] ram_rdata;
    logic                    out_free;

    assign o_ready          = (r_state == S_IDLE);
    assign accept           = i_valid && o_ready;
    assign o_valid          = r_out_valid;
    assign o_result_code    = r_out_code;
    assign o_slot_out       = r_out_slot;
    assign o_payload_out    = r_out_payload;
    assign o_created_count  = r_out_created;
    assign o_prepared_count = r_out_prepared;

    // occupied window and status match, rotated so that head sits at bit 0
    assign full    = r_head_valid && (r_head == r_tail);
    assign occ     = r_tail - r_head;
    assign target  = t_status'(i_wanted_status + WANT_W'(1));
    assign head_st = r_status[r_head];

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = r_head_valid && (r_status[i] == target)
                       && (full || (SLOT_W'(SLOT_W'(i) - r_head) < occ));
        end
        for (int k = 0; k < SLOTS; k++) begin
            match_rot[k] = match[SLOT_W'(r_head + SLOT_W'(k))];
        end
        pick_off = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (match_rot[k]) begin
                pick_off = SLOT_W'(k);
            end
        end
    end

    assign found_any = (|match_rot) && !i_wanted_status[WANT_W-1];
    assign pick_slot = r_head + pick_off;
    assign idx       = i_slot_index[SLOT_W-1:0];
    assign bad_idx   = ((IDX_W + 1)'(i_slot_index) >= (IDX_W + 1)'(SLOTS));
    assign need      = (t_action'(i_action) == ACT_PREPARE) ? ST_CREATED : ST_PREPARED;
    assign out_free  = !r_out_valid || i_ready;

    assign ram_we = accept && (t_action'(i_action) == ACT_PUSH)
                    && !(full && (head_st != ST_SENT) && (head_st != ST_EMPTY));
    assign ram_re = accept && (t_action'(i_action) == ACT_FIND);

    rqss_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SLOTS)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_payload_in),
        .i_re    (ram_re),
        .i_raddr (pick_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_status       = r_status;
        n_head         = r_head;
        n_head_valid   = r_head_valid;
        n_tail         = r_tail;
        n_created      = r_created;
        n_prepared     = r_prepared;
        n_pend_code    = r_pend_code;
        n_pend_slot    = r_pend_slot;
        n_pend_found   = r_pend_found;
        n_out_valid    = r_out_valid;
        n_out_code     = r_out_code;
        n_out_slot     = r_out_slot;
        n_out_payload  = r_out_payload;
        n_out_created  = r_out_created;
        n_out_prepared = r_out_prepared;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state      = S_RESULT;
                    n_pend_code  = RC_OK;
                    n_pend_slot  = '0;
                    n_pend_found = 1'b0;
                    case (t_action'(i_action))
                        ACT_PUSH: begin
                            if (ram_we) begin
                                if (full) begin
                                    n_head = r_head + SLOT_W'(1);
                                end
                                if (!r_head_valid) begin
                                    n_head_valid = 1'b1;
                                    n_head       = r_tail;
                                end
                                n_status[r_tail] = ST_CREATED;
                                n_tail           = r_tail + SLOT_W'(1);
                                if (r_created < CNT_W'(SLOTS)) begin
                                    n_created = r_created + CNT_W'(1);
                                end
                                n_pend_slot = r_tail;
                            end else begin
                                n_pend_code = RC_FULL;
                            end
                        end
                        ACT_FIND: begin
                            if (found_any) begin
                                n_pend_slot  = pick_slot;
                                n_pend_found = 1'b1;
                            end else begin
                                n_pend_code = RC_NOT_FOUND;
                            end
                        end
                        ACT_PREPARE, ACT_SEND: begin
                            if (bad_idx) begin
                                n_pend_code = RC_BAD_INDEX;
                            end else if (r_status[idx] != need) begin
                                n_pend_code = RC_WRONG_STATUS;
                            end else if (t_action'(i_action) == ACT_PREPARE) begin
                                n_status[idx] = ST_PREPARED;
                                if (r_created != '0) begin
                                    n_created = r_created - CNT_W'(1);
                                end
                                if (r_prepared < CNT_W'(SLOTS)) begin
                                    n_prepared = r_prepared + CNT_W'(1);
                                end
                            end else begin
                                n_status[idx] = ST_SENT;
                                if (r_prepared != '0) begin
                                    n_prepared = r_prepared - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            n_pend_code = RC_OK;
                        end
                    endcase
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state        = S_IDLE;
                    n_out_valid    = 1'b1;
                    n_out_code     = r_pend_code;
                    n_out_slot     = r_pend_slot;
                    n_out_payload  = r_pend_found ? ram_rdata : '0;
                    n_out_created  = r_created;
                    n_out_prepared = r_prepared;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= ST_EMPTY;
            end
            r_head         <= '0;
            r_head_valid   <= 1'b0;
            r_tail         <= '0;
            r_created      <= '0;
            r_prepared     <= '0;
            r_pend_code    <= RC_OK;
            r_pend_slot    <= '0;
            r_pend_found   <= 1'b0;
            r_out_valid    <= 1'b0;
            r_out_code     <= RC_OK;
            r_out_slot     <= '0;
            r_out_payload  <= '0;
            r_out_created  <= '0;
            r_out_prepared <= '0;
        end else begin
            r_state        <= n_state;
            r_status       <= n_status;
            r_head         <= n_head;
            r_head_valid   <= n_head_valid;
            r_tail         <= n_tail;
            r_created      <= n_created;
            r_prepared     <= n_prepared;
            r_pend_code    <= n_pend_code;
            r_pend_slot    <= n_pend_slot;
            r_pend_found   <= n_pend_found;
            r_out_valid    <= n_out_valid;
            r_out_code     <= n_out_code;
            r_out_slot     <= n_out_slot;
            r_out_payload  <= n_out_payload;
            r_out_created  <= n_out_created;
            r_out_prepared <= n_out_prepared;
        end
    end

endmodule

`default_nettype wire

// File: sv/rqss_checker.sv
// port-level checker for the ring queue with slot status, bound to the top level
// depends on rqss_pkg and ring_queue_with_slot_status_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "ring_queue_with_slot_status_macros.svh"

module rqss_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                o_ready,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic [rqss_pkg::CODE_W-1:0]         o_result_code,
    input wire logic [rqss_pkg::SLOT_W-1:0]         o_slot_out,
    input wire logic [rqss_pkg::PAYLOAD_BITS-1:0]   o_payload_out,
    input wire logic [rqss_pkg::CNT_W-1:0]          o_created_count,
    input wire logic [rqss_pkg::CNT_W-1:0]          o_prepared_count
);

    import rqss_pkg::*;

    // a stalled result item holds
    `RQSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_result_code) && $stable(o_slot_out) && $stable(o_payload_out), "result item changed while stalled")

    // one item at a time: no request taken in the cycle after an accept
    `RQSS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "request taken while previous item in flight")

    // failed requests report slot and payload as zero
    `RQSS_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_valid && (o_result_code != RC_OK), (o_slot_out == '0) && (o_payload_out == '0), "failed request with nonzero slot or payload")

    // created and prepared slots never exceed the ring size
    `RQSS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_valid, (o_created_count + o_prepared_count) <= SLOTS, "slot counts exceed ring size")

    // result code is always a defined code
    `RQSS_ASSERT_NOW(a_code_range, i_clk, i_rst_n, o_valid, o_result_code <= RC_WRONG_STATUS, "undefined result code")

endmodule

bind ring_queue_with_slot_status rqss_checker u_rqss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_result_code    (o_result_code),
    .o_slot_out       (o_slot_out),
    .o_payload_out    (o_payload_out),
    .o_created_count  (o_created_count),
    .o_prepared_count (o_prepared_count)
);

`default_nettype wire

// File: tb/ring_queue_with_slot_status_tb.sv
// testbench for the ring queue with per-slot status: directed then random requests
// depends on rqss_pkg and ring_queue_with_slot_status; a scoreboard class predicts replies
`timescale 1ns / 1ps

module ring_queue_with_slot_status_tb;
    import rqss_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1430;

    typedef struct {
        logic [CODE_W-1:0]       code;
        logic [SLOT_W-1:0]       slot;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [CNT_W-1:0]        created;
        logic [CNT_W-1:0]        prepared;
    } t_reply;

    class ring_scoreboard;
        t_status                 status_of [SLOTS];
        logic [PAYLOAD_BITS-1:0] payload_of [SLOTS];
        logic [SLOT_W-1:0]       head;
        logic [SLOT_W-1:0]       tail;
        bit                      ring_live;
        int                      created_n;
        int                      prepared_n;
        t_reply                  replies_due [$];
        int                      errors;
        int                      requests;
        int                      code_seen [5];

        function new();
            foreach (status_of[i]) begin
                status_of[i] = ST_EMPTY;
                payload_of[i] = '0;
            end
            head = '0;
            tail = '0;
            ring_live = 1'b0;
            created_n = 0;
            prepared_n = 0;
            errors = 0;
            requests = 0;
            foreach (code_seen[i]) code_seen[i] = 0;
        endfunction

        function int random_slot_in(t_status s);
            int hits [$];
            foreach (status_of[i]) if (status_of[i] == s) hits.push_back(i);
            if (hits.size() == 0) return -1;
            return hits[$urandom_range(hits.size() - 1)];
        endfunction

        function void note_request(t_action act, logic [PAYLOAD_BITS-1:0] pl,
                                   logic [IDX_W-1:0] idx, logic [WANT_W-1:0] want);
            t_reply            r;
            bit                ok;
            bit                hit;
            bit                stop;
            logic [SLOT_W-1:0] p;
            t_status           need;
            r.code = RC_OK;
            r.slot = '0;
            r.payload = '0;
            case (act)
                ACT_PUSH: begin
                    ok = 1'b1;
                    if (ring_live && head == tail) begin
                        if (status_of[head] == ST_SENT || status_of[head] == ST_EMPTY) begin
                            status_of[head] = ST_EMPTY;
                            head = head + 1'b1;
                        end else begin
                            ok = 1'b0;
                            r.code = RC_FULL;
                        end
                    end
                    if (ok) begin
                        if (!ring_live) begin
                            ring_live = 1'b1;
                            head = tail;
                        end
                        status_of[tail] = ST_CREATED;
                        payload_of[tail] = pl;
                        r.slot = tail;
                        tail = tail + 1'b1;
                        if (created_n < SLOTS) created_n++;
                    end
                end
                ACT_FIND: begin
                    r.code = RC_NOT_FOUND;
                    if (ring_live && want < 2) begin
                        p = head;
                        hit = 1'b0;
                        stop = 1'b0;
                        for (int n = 0; n < SLOTS && !hit && !stop; n++) begin
                            if (status_of[p] == t_status'(want + 2'd1)) begin
                                hit = 1'b1;
                                r.code = RC_OK;
                                r.slot = p;
                                r.payload = payload_of[p];
                            end else begin
                                p = p + 1'b1;
                                if (p == tail) stop = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    need = (act == ACT_PREPARE) ? ST_CREATED : ST_PREPARED;
                    if (idx >= SLOTS) begin
                        r.code = RC_BAD_INDEX;
                    end else if (status_of[idx[SLOT_W-1:0]] != need) begin
                        r.code = RC_WRONG_STATUS;
                    end else if (act == ACT_PREPARE) begin
                        status_of[idx[SLOT_W-1:0]] = ST_PREPARED;
                        if (created_n > 0) created_n--;
                        if (prepared_n < SLOTS) prepared_n++;
                    end else begin
                        status_of[idx[SLOT_W-1:0]] = ST_SENT;
                        if (prepared_n > 0) prepared_n--;
                    end
                end
            endcase
            r.created = created_n[CNT_W-1:0];
            r.prepared = prepared_n[CNT_W-1:0];
            replies_due.push_back(r);
            requests++;
            code_seen[r.code]++;
        endfunction

        function void check_reply(t_reply got);
            t_reply want_r;
            if (replies_due.size() == 0) begin
                $display("%0t: reply with no request waiting, code %0d slot %0d",
                         $time, got.code, got.slot);
                errors++;
                return;
            end
            want_r = replies_due.pop_front();
            if (got.code !== want_r.code) begin
                $display("%0t: result_code expected %0d actual %0d",
                         $time, want_r.code, got.code);
                errors++;
            end
            if (got.slot !== want_r.slot) begin
                $display("%0t: slot_out expected %0d actual %0d",
                         $time, want_r.slot, got.slot);
                errors++;
            end
            if (got.payload !== want_r.payload) begin
                $display("%0t: payload_out expected %h actual %h",
                         $time, want_r.payload, got.payload);
                errors++;
            end
            if (got.created !== want_r.created) begin
                $display("%0t: created_count expected %0d actual %0d",
                         $time, want_r.created, got.created);
                errors++;
            end
            if (got.prepared !== want_r.prepared) begin
                $display("%0t: prepared_count expected %0d actual %0d",
                         $time, want_r.prepared, got.prepared);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [ACT_W-1:0]        i_action = '0;
    logic [PAYLOAD_BITS-1:0] i_payload_in = '0;
    logic [IDX_W-1:0]        i_slot_index = '0;
    logic [WANT_W-1:0]       i_wanted_status = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [CODE_W-1:0]       o_result_code;
    logic [SLOT_W-1:0]       o_slot_out;
    logic [PAYLOAD_BITS-1:0] o_payload_out;
    logic [CNT_W-1:0]        o_created_count;
    logic [CNT_W-1:0]        o_prepared_count;

    bit                      quiet = 1'b0;
    int                      idle_cycles = 0;
    ring_scoreboard          sb;

    ring_queue_with_slot_status dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_payload_in     (i_payload_in),
        .i_slot_index     (i_slot_index),
        .i_wanted_status  (i_wanted_status),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_code    (o_result_code),
        .o_slot_out       (o_slot_out),
        .o_payload_out    (o_payload_out),
        .o_created_count  (o_created_count),
        .o_prepared_count (o_prepared_count)
    );

    always #5 i_clk = ~i_clk;

    // reply monitor and receiver stalls
    always @(posedge i_clk) begin
        t_reply got;
        if (i_rst_n && o_valid && i_ready) begin
            got.code = o_result_code;
            got.slot = o_slot_out;
            got.payload = o_payload_out;
            got.created = o_created_count;
            got.prepared = o_prepared_count;
            sb.check_reply(got);
        end
        i_ready <= quiet || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("ring_queue_with_slot_status_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue_request(t_action act, logic [PAYLOAD_BITS-1:0] pl,
                                 logic [IDX_W-1:0] idx, logic [WANT_W-1:0] want);
        while (!quiet && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_payload_in <= pl;
        i_slot_index <= idx;
        i_wanted_status <= want;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(act, pl, idx, want);
    endtask

    task automatic run_directed();
        // empty ring: every find misses, bad index on prepare and send, wrong status on prepare
        issue_request(ACT_FIND, '1, 8'hff, 2'd0);
        issue_request(ACT_FIND, '0, 8'h00, 2'd1);
        issue_request(ACT_FIND, '0, 8'h00, 2'd2);
        issue_request(ACT_FIND, '0, 8'h00, 2'd3);
        issue_request(ACT_PREPARE, '0, 8'd255, 2'd0);
        issue_request(ACT_SEND, '0, 8'd16, 2'd0);
        issue_request(ACT_PREPARE, '0, 8'd3, 2'd0);
        // first push, payload extremes
        issue_request(ACT_PUSH, 32'h0000_0000, 8'd0, 2'd0);
        issue_request(ACT_PUSH, 32'hffff_ffff, 8'd0, 2'd0);
        issue_request(ACT_PUSH, 32'ha5a5_5a5a, 8'd0, 2'd0);
        issue_request(ACT_FIND, '0, 8'd0, 2'd0);
        issue_request(ACT_FIND, '0, 8'd0, 2'd1);
        issue_request(ACT_FIND, '0, 8'd0, 2'd2);
        // walk slot 1 through prepare and send
        issue_request(ACT_PREPARE, '0, 8'd1, 2'd0);
        issue_request(ACT_PREPARE, '0, 8'd1, 2'd0);
        issue_request(ACT_SEND, '0, 8'd0, 2'd0);
        issue_request(ACT_FIND, '0, 8'd0, 2'd1);
        issue_request(ACT_SEND, '0, 8'd1, 2'd0);
        issue_request(ACT_SEND, '0, 8'd1, 2'd0);
        issue_request(ACT_FIND, '0, 8'd0, 2'd2);
        issue_request(ACT_FIND, '0, 8'd0, 2'd3);
        issue_request(ACT_PREPARE, '0, 8'd15, 2'd0);
        issue_request(ACT_PREPARE, '0, 8'd16, 2'd0);
    endtask

    task automatic run_random(int count);
        t_action                 act;
        logic [PAYLOAD_BITS-1:0] pl;
        logic [IDX_W-1:0]        idx;
        logic [WANT_W-1:0]       want;
        int                      roll;
        int                      pick;
        for (int k = 0; k < count; k++) begin
            quiet = (k >= 600 && k < 900);
            roll = $urandom_range(99);
            pl = $urandom;
            idx = IDX_W'($urandom_range(255));
            want = WANT_W'($urandom_range(3));
            if (roll < 35) act = ACT_PUSH;
            else if (roll < 55) act = ACT_FIND;
            else if (roll < 80) act = ACT_PREPARE;
            else act = ACT_SEND;
            if (act == ACT_PUSH && $urandom_range(19) == 0) begin
                pl = $urandom_range(1) ? '0 : '1;
            end
            if (act == ACT_PREPARE || act == ACT_SEND) begin
                pick = sb.random_slot_in(act == ACT_PREPARE ? ST_CREATED : ST_PREPARED);
                roll = $urandom_range(99);
                if (roll < 75 && pick >= 0) idx = IDX_W'(pick);
                else if (roll < 90) idx = IDX_W'($urandom_range(SLOTS - 1));
            end
            issue_request(act, pl, idx, want);
        end
        quiet = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(RANDOM_ITEMS);
        i_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d requests: %0d ok, %0d refused full, %0d not found,",
                 sb.requests, sb.code_seen[RC_OK], sb.code_seen[RC_FULL],
                 sb.code_seen[RC_NOT_FOUND]);
        $display("%0d bad index, %0d wrong status",
                 sb.code_seen[RC_BAD_INDEX], sb.code_seen[RC_WRONG_STATUS]);
        $display("random stalls on both channels, with a stretch of 300 requests at full rate");
        if (sb.errors == 0 && sb.replies_due.size() == 0) begin
            $display("ring_queue_with_slot_status_tb: PASS");
        end else begin
            $display("ring_queue_with_slot_status_tb: FAIL");
        end
        $finish;
    end

endmodule
